>>> sv/flsa_pkg.sv
// Shared types, constants and codes for the free list slot allocator.
package flsa_pkg;

	// Pool size and derived widths
	localparam int SLOTS  = 16;
	localparam int SLOT_W = 5;
	localparam int LINK_W = $clog2(SLOTS + 2);
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Request action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Response status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EMPTY        = 2'd1;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [1:0] ST_INVALID      = 2'd3;

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic [1:0]        status;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic commit;
	} flsa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_busy;
	} flsa_sts_t;

endpackage

>>> sv/flsa_ctrl.sv
// Controller state machine: sequences load and commit of one request word.
module flsa_ctrl import flsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  flsa_sts_t sts,
	output flsa_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait until the response register can take the result
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> sv/flsa_dp.sv
// Datapath: head register, link memory with valid bits, and response register.
module flsa_dp import flsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  flsa_cmd_t cmd,
	output flsa_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_t      rsp
);

	logic [LINK_W-1:0] link_mem [SLOTS];
	logic [SLOTS-1:0]  link_vld_q;
	logic [LINK_W-1:0] head_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              action_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LINK_W-1:0] rd_head_q;
	logic [LINK_W-1:0] rd_slot_q;
	logic              rd_head_vld_q;
	logic              rd_slot_vld_q;

	logic [LINK_W-1:0] head_dec;
	logic [SLOT_W-1:0] req_slot_dec;
	logic [SLOT_W-1:0] slot_dec;
	logic [ADDR_W-1:0] head_addr;
	logic [ADDR_W-1:0] req_slot_addr;
	logic [ADDR_W-1:0] slot_addr;

	logic [LINK_W-1:0] link_head;
	logic [LINK_W-1:0] link_slot;
	logic              head_ok;
	logic              slot_ok;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [LINK_W-1:0] wr_data;
	logic              head_wr;
	logic [LINK_W-1:0] head_nxt;
	rsp_t              rsp_nxt;

	// Slot n lives at address n-1
	assign head_dec      = head_q - LINK_W'(1);
	assign req_slot_dec  = req.slot - SLOT_W'(1);
	assign slot_dec      = slot_q - SLOT_W'(1);
	assign head_addr     = head_dec[ADDR_W-1:0];
	assign req_slot_addr = req_slot_dec[ADDR_W-1:0];
	assign slot_addr     = slot_dec[ADDR_W-1:0];

	// An unwritten entry reads as its reset link: slot n points at n+1
	assign link_head = rd_head_vld_q ? rd_head_q : head_q + LINK_W'(1);
	assign link_slot = rd_slot_vld_q ? rd_slot_q : LINK_W'(slot_q) + LINK_W'(1);

	assign head_ok = (head_q != '0) && (head_q <= LINK_W'(SLOTS));
	assign slot_ok = (slot_q != '0) && (slot_q <= SLOT_W'(SLOTS));

	// Allocate pops the head, free pushes the slot in front of it
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = head_addr;
		wr_data  = '0;
		head_wr  = 1'b0;
		head_nxt = head_q;
		rsp_nxt.granted_slot = '0;
		rsp_nxt.status       = ST_OK;
		unique case (action_q)
			ACT_ALLOC: begin
				if (!head_ok) begin
					rsp_nxt.status = ST_EMPTY;
				end else begin
					rsp_nxt.granted_slot = SLOT_W'(head_q);
					wr_en    = 1'b1;
					wr_addr  = head_addr;
					wr_data  = '0;
					head_wr  = 1'b1;
					head_nxt = link_head;
				end
			end
			ACT_FREE: begin
				priority if (!slot_ok) begin
					rsp_nxt.status = ST_INVALID;
				end else if (link_slot != '0) begin
					rsp_nxt.status = ST_ALREADY_FREE;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = slot_addr;
					wr_data  = head_q;
					head_wr  = 1'b1;
					head_nxt = LINK_W'(slot_q);
				end
			end
			default: rsp_nxt.status = ST_OK;
		endcase
	end

	// Captured request and link memory ports
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q      <= req.action;
			slot_q        <= req.slot;
			rd_head_q     <= link_mem[head_addr];
			rd_slot_q     <= link_mem[req_slot_addr];
			rd_head_vld_q <= link_vld_q[head_addr];
			rd_slot_vld_q <= link_vld_q[req_slot_addr];
		end
		if (cmd.commit && wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	// Control state: head, entry valid bits, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= LINK_W'(1);
			link_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && head_wr) begin
				head_q <= head_nxt;
			end
			if (cmd.commit && wr_en) begin
				link_vld_q[wr_addr] <= 1'b1;
			end
			rsp_valid_q <= cmd.commit || (rsp_valid_q && rsp_stall);
		end
	end

	assign sts.out_busy = rsp_valid_q && rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

>>> sv/free_list_slot_allocator.sv
// Order: a request word is captured when accepted, then committed once the response
// register is free; the response word is registered at the commit. A new request
// word is stalled until the previous one commits; a held response stalls the commit.
// Reset: asynchronous, active low; head returns to slot 1 and all link valid
// bits clear, so every slot reads as free and chained in order at once.
module free_list_slot_allocator import flsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	flsa_cmd_t cmd;
	flsa_sts_t sts;

	flsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	flsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
